// ----- sv/nct_pkg.sv -----
// ----------------------------------------------------------------------------
// nct_pkg
// Shared types and constants of the node congestion table.
// ----------------------------------------------------------------------------
package nct_pkg;

  localparam int unsigned NODES  = 256;
  localparam int unsigned NodeAw = $clog2(NODES);
  localparam int unsigned FillW  = 16;
  localparam int unsigned LevelW = FillW + 1;
  localparam int unsigned CntW   = $clog2(FillW) + 1;

  localparam logic [LevelW-1:0] OneQ16 = LevelW'(1) << FillW;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  localparam logic [1:0] CfgBaseDelay = 2'd0;
  localparam logic [1:0] CfgGain      = 2'd1;
  localparam logic [1:0] CfgDropLevel = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_SCALE,
    ST_DELAY
  } state_e;

endpackage

// ----- sv/nct_div.sv -----
// ----------------------------------------------------------------------------
// nct_div
// Restoring divider, one quotient bit per cycle: (dividend << FillW) / divisor
// for dividend below divisor.
// ----------------------------------------------------------------------------
module nct_div
  import nct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [FillW-1:0] dividend_i,
  input  logic [FillW-1:0] divisor_i,
  output logic             done_o,
  output logic [FillW-1:0] quot_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [FillW-1:0] rem_q, rem_d;
  logic [FillW-1:0] quot_q, quot_d;
  logic [FillW-1:0] dsor_q, dsor_d;
  logic [FillW:0]   rem_shift;
  logic             fits;

  assign rem_shift = {rem_q, 1'b0};
  assign fits      = rem_shift >= {1'b0, dsor_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dsor_d = dsor_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i;
      quot_d = '0;
      dsor_d = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? FillW'(rem_shift - {1'b0, dsor_q}) : rem_shift[FillW-1:0];
      quot_d = {quot_q[FillW-2:0], fits};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(FillW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsor_q <= dsor_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider not busy after start");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

// ----- sv/node_congestion_table_unit.sv -----
// ----------------------------------------------------------------------------
// node_congestion_table_unit
// Per-node congestion levels in Q1.16 with hop delay and drop decision.
// ----------------------------------------------------------------------------
// One item at a time: busy stays high from the accepting edge until the
// result strobe. A query passes the read, scale and delay states; a clear or
// an update whose level is settled without division (zero capacity, full
// queue) skips the read, and any other update waits in the division state
// for the one-bit-per-cycle divider, followed by the two registered multiplies
// of the delay path. Levels live in a 256-entry synchronous RAM with
// registered read data; each entry has a valid flip-flop, which a clear
// resets. Results appear for one cycle with done_o and cannot be held off.
module node_congestion_table_unit
  import nct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func_i,
  input  logic [7:0]        node_i,
  input  logic [15:0]       occupancy_i,
  input  logic [15:0]       capacity_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [23:0]       cfg_data_i,
  output logic              done_o,
  output logic [16:0]       level_o,
  output logic [24:0]       hop_delay_o,
  output logic              drop_o
);

  state_e state_q, state_d;

  logic [23:0]        base_q;
  logic [16:0]        gain_q;
  logic [16:0]        drop_lvl_q;

  logic [LevelW-1:0]  mem [NODES];
  logic [LevelW-1:0]  rd_data_q;
  logic [NODES-1:0]   valid_q;

  logic [NodeAw-1:0]  node_q;
  logic               in_range_q;
  logic [LevelW-1:0]  lvl_q, lvl_d;
  logic [LevelW-1:0]  scaled_q;
  logic               done_q;
  logic [16:0]        level_q;
  logic [24:0]        hop_q;
  logic               drop_q;

  logic               accept;
  logic               in_range;
  logic               is_update, is_clear;
  logic               direct_lvl;
  logic [LevelW-1:0]  direct_val;
  logic               div_start, div_done;
  logic [FillW-1:0]   div_quot;
  logic               mem_we, mem_re;
  logic [NodeAw-1:0]  mem_addr;
  logic [LevelW-1:0]  mem_wdata;
  logic               clear_all;
  logic [2*LevelW-1:0] scale_prod;
  logic [LevelW:0]    delay_factor;
  logic [41:0]        delay_prod;

  assign accept    = start && !busy;
  assign in_range  = 32'(node_i) < 32'(NODES);
  assign is_update = func_i == FUNC_UPDATE;
  assign is_clear  = func_i == FUNC_CLEAR;

  assign direct_lvl = !in_range || capacity_i == '0 || occupancy_i >= capacity_i;
  always_comb begin
    if (capacity_i == '0) begin
      direct_val = '0;
    end else begin
      direct_val = OneQ16;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_UPDATE: state_d = direct_lvl ? ST_SCALE : ST_DIV;
            FUNC_CLEAR:  state_d = ST_SCALE;
            default:     state_d = ST_READ;
          endcase
        end
      end
      ST_READ:  state_d = ST_SCALE;
      ST_DIV:   state_d = div_done ? ST_SCALE : ST_DIV;
      ST_SCALE: state_d = ST_DELAY;
      ST_DELAY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = node_q;
    mem_wdata = direct_val;
    clear_all = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        mem_addr  = node_i[NodeAw-1:0];
        mem_re    = accept && !is_update && !is_clear;
        mem_we    = accept && is_update && in_range && direct_lvl;
        clear_all = accept && is_clear;
        div_start = accept && is_update && !direct_lvl;
      end
      ST_DIV: begin
        mem_we    = div_done;
        mem_wdata = {1'b0, div_quot};
      end
      default: begin
      end
    endcase
  end

  // level of the item
  always_comb begin
    lvl_d = lvl_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          lvl_d = (is_update && direct_lvl && in_range) ? direct_val : '0;
        end
      end
      ST_READ: begin
        lvl_d = (in_range_q && valid_q[node_q]) ? rd_data_q : '0;
      end
      ST_DIV: begin
        if (div_done) begin
          lvl_d = {1'b0, div_quot};
        end
      end
      default: begin
      end
    endcase
  end

  nct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (occupancy_i[FillW-1:0]),
    .divisor_i  (capacity_i[FillW-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign scale_prod   = gain_q * lvl_q;
  assign delay_factor = {1'b0, OneQ16} + {1'b0, scaled_q};
  assign delay_prod   = base_q * delay_factor;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_all) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[mem_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      base_q     <= 24'd256;
      gain_q     <= 17'd32768;
      drop_lvl_q <= 17'd65536;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == ST_DELAY;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgBaseDelay: begin
            if (cfg_data_i != '0) begin
              base_q <= cfg_data_i;
            end
          end
          CfgGain: begin
            if (cfg_data_i[16:0] <= OneQ16) begin
              gain_q <= cfg_data_i[16:0];
            end
          end
          CfgDropLevel: drop_lvl_q <= cfg_data_i[16:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    if (accept) begin
      node_q     <= node_i[NodeAw-1:0];
      in_range_q <= in_range;
    end
    if (state_q == ST_SCALE) begin
      scaled_q <= scale_prod[2*FillW:FillW];
    end
    if (state_q == ST_DELAY) begin
      level_q <= lvl_q;
      hop_q   <= delay_prod[40:16];
      drop_q  <= lvl_q >= drop_lvl_q;
    end
  end

  assign busy        = state_q != ST_IDLE;
  assign done_o      = done_q;
  assign level_o     = level_q;
  assign hop_delay_o = hop_q;
  assign drop_o      = drop_q;

  a_done_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result strobe outside idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after transfer");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("quotient arrived outside division wait");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

endmodule

// ----- tb/tb_node_congestion_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_node_congestion_table_unit
// Self-checking bench for the node congestion table. A short directed run
// covers empty and full queues, zero capacity, the spare function code and
// clears. Random update, query and clear traffic then runs under several
// register settings, with random sender gaps. Each result strobe is checked
// against a bench-side model of levels, hop delay and drop decision.
// ----------------------------------------------------------------------------
module tb_node_congestion_table_unit;
  import nct_pkg::*;

  localparam logic [1:0]  FuncSpare     = 2'd3;
  localparam logic [1:0]  CfgSpare      = 2'd3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned PhaseItems    = 127;
  localparam int unsigned NumPhases     = 12;

  typedef struct packed {
    logic [16:0] level;
    logic [24:0] hop_delay;
    logic        drop;
  } hop_result_t;

  class congestion_scoreboard;
    logic [23:0]  hop_base;
    logic [16:0]  gain;
    logic [16:0]  drop_thr;
    logic [16:0]  level_mem [NODES];
    bit           node_live [NODES];
    hop_result_t  awaited [$];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
      hop_base   = 24'd256;
      gain       = 17'd32768;
      drop_thr   = OneQ16;
      foreach (node_live[i]) node_live[i] = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CfgBaseDelay: if (data != '0) hop_base = data;
        CfgGain:      if (data[16:0] <= OneQ16) gain = data[16:0];
        CfgDropLevel: drop_thr = data[16:0];
        default: ;
      endcase
    endfunction

    function logic [16:0] level_of_fill(logic [15:0] occ, logic [15:0] cap);
      logic [31:0] ratio;
      if (cap == '0) return '0;
      if (occ >= cap) return OneQ16;
      ratio = {occ, 16'h0000} / {16'h0000, cap};
      return ratio[16:0];
    endfunction

    function logic [24:0] delay_for_level(logic [16:0] lvl);
      logic [63:0] prod;
      prod = (64'(gain) * 64'(lvl)) >> 16;
      prod = (64'(hop_base) * (64'(OneQ16) + prod)) >> 16;
      return prod[24:0];
    endfunction

    function void note_transfer(logic [1:0] func, logic [7:0] node,
                                logic [15:0] occ, logic [15:0] cap);
      hop_result_t r;
      logic [16:0] lvl;
      lvl = '0;
      case (func)
        FUNC_CLEAR: foreach (node_live[i]) node_live[i] = 1'b0;
        FUNC_UPDATE: begin
          lvl = level_of_fill(occ, cap);
          level_mem[node] = lvl;
          node_live[node] = 1'b1;
        end
        default: if (node_live[node]) lvl = level_mem[node];
      endcase
      r.level     = lvl;
      r.hop_delay = delay_for_level(lvl);
      r.drop      = (lvl >= drop_thr);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [16:0] level, logic [24:0] hop_delay, logic drop);
      hop_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: level %0d, hop_delay %0d, drop %0b",
                 $time, level, hop_delay, drop);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (level !== want.level) begin
        $display("%0t: level mismatch: expected %0d, actual %0d", $time, want.level, level);
        mismatches++;
      end
      if (hop_delay !== want.hop_delay) begin
        $display("%0t: hop_delay mismatch: expected %0d, actual %0d",
                 $time, want.hop_delay, hop_delay);
        mismatches++;
      end
      if (drop !== want.drop) begin
        $display("%0t: drop mismatch: expected %0b, actual %0b", $time, want.drop, drop);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  logic [1:0]  func_i      = FUNC_QUERY;
  logic [7:0]  node_i      = '0;
  logic [15:0] occupancy_i = '0;
  logic [15:0] capacity_i  = '0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [23:0] cfg_data_i  = '0;
  logic        done_o;
  logic [16:0] level_o;
  logic [24:0] hop_delay_o;
  logic        drop_o;

  congestion_scoreboard sb;
  bit          idle_en;
  bit          ever_written [NODES];
  int unsigned written_list [$];
  int unsigned quiet_cycles = 0;
  int unsigned n_items  = 0;
  int unsigned n_update = 0;
  int unsigned n_query  = 0;
  int unsigned n_clear  = 0;
  int unsigned n_cfg    = 0;

  always #2 clk_i = ~clk_i;

  node_congestion_table_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .node_i      (node_i),
    .occupancy_i (occupancy_i),
    .capacity_i  (capacity_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .level_o     (level_o),
    .hop_delay_o (hop_delay_o),
    .drop_o      (drop_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(level_o, hop_delay_o, drop_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
      $display("node_congestion_table_unit regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] func, input logic [7:0] node,
                           input logic [15:0] occ, input logic [15:0] cap);
    if (idle_en && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    start       <= 1'b1;
    func_i      <= func;
    node_i      <= node;
    occupancy_i <= occ;
    capacity_i  <= cap;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_transfer(func, node, occ, cap);
    n_items++;
    case (func)
      FUNC_UPDATE: begin
        n_update++;
        if (!ever_written[node]) begin
          ever_written[node] = 1'b1;
          written_list.push_back(32'(node));
        end
      end
      FUNC_CLEAR: n_clear++;
      default: n_query++;
    endcase
  endtask

  task automatic hold_sender();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
    n_cfg++;
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [1:0]  func;
    logic [7:0]  node;
    logic [15:0] occ;
    logic [15:0] cap;
    pick = $urandom_range(99);
    node = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    occ  = 16'($urandom);
    cap  = 16'($urandom);
    case ($urandom_range(5))
      0: cap = '0;
      1: occ = cap + 16'($urandom_range(3));
      2: begin
        occ = 16'($urandom_range(255));
        cap = 16'($urandom_range(255));
      end
      3: cap = 16'hFFFF;
      default: ;
    endcase
    if (pick < 50 || written_list.size() == 0) begin
      func = FUNC_UPDATE;
    end else if (pick < 96) begin
      // mostly query nodes that hold a written level, live or cleared
      func = (pick < 92) ? FUNC_QUERY : FuncSpare;
      if ($urandom_range(4) != 0) begin
        node = 8'(written_list[$urandom_range(written_list.size() - 1)]);
      end
    end else begin
      func = FUNC_CLEAR;
    end
    send_item(func, node, occ, cap);
  endtask

  initial begin
    sb = new();
    idle_en = 1'b1;
    foreach (ever_written[i]) ever_written[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(FUNC_UPDATE, 8'd0,   16'd0,     16'd0);
    send_item(FUNC_UPDATE, 8'd255, 16'hFFFF,  16'hFFFF);
    send_item(FUNC_UPDATE, 8'd1,   16'hFFFF,  16'd0);
    send_item(FUNC_UPDATE, 8'd2,   16'd1,     16'hFFFF);
    send_item(FUNC_UPDATE, 8'd3,   16'hFFFE,  16'hFFFF);
    send_item(FUNC_UPDATE, 8'd4,   16'hFFFF,  16'd1);
    send_item(FUNC_UPDATE, 8'd5,   16'd0,     16'd1);
    send_item(FUNC_UPDATE, 8'd6,   16'd1,     16'd3);
    send_item(FUNC_UPDATE, 8'd7,   16'h8000,  16'hFFFF);
    send_item(FUNC_QUERY,  8'd255, 16'd0,     16'd0);
    send_item(FUNC_QUERY,  8'd3,   16'd0,     16'd0);
    send_item(FUNC_QUERY,  8'd0,   16'd0,     16'd0);
    send_item(FuncSpare,   8'd6,   16'hFFFF,  16'hFFFF);
    send_item(FUNC_CLEAR,  8'd0,   16'hFFFF,  16'hFFFF);
    send_item(FUNC_QUERY,  8'd255, 16'd0,     16'd0);
    send_item(FuncSpare,   8'd3,   16'd0,     16'd0);
    send_item(FUNC_UPDATE, 8'd255, 16'hAAAA,  16'h5555);
    send_item(FUNC_UPDATE, 8'd3,   16'h5555,  16'hAAAA);
    send_item(FUNC_QUERY,  8'd255, 16'h5555,  16'hAAAA);
    send_item(FUNC_QUERY,  8'd3,   16'hAAAA,  16'h5555);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        hold_sender();
        case (p)
          1: begin
            write_reg(CfgBaseDelay, 24'd1);
            write_reg(CfgGain, 24'd0);
            write_reg(CfgDropLevel, 24'd0);
            write_reg(CfgBaseDelay, 24'd0);
          end
          2: begin
            write_reg(CfgBaseDelay, 24'hFFFFFF);
            write_reg(CfgGain, 24'd65536);
            write_reg(CfgDropLevel, 24'd65536);
          end
          3: begin
            write_reg(CfgGain, 24'd65537);
            write_reg(CfgDropLevel, 24'd65537);
            write_reg(CfgSpare, 24'hFFFFFF);
          end
          default: begin
            write_reg(CfgBaseDelay, ($urandom_range(4) == 0) ? 24'($urandom)
                                                             : 24'($urandom_range(1, 4096)));
            write_reg(CfgGain, ($urandom_range(4) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(0, 65536)));
            write_reg(CfgDropLevel, ($urandom_range(4) == 0) ? 24'($urandom)
                                                             : 24'($urandom_range(0, 65536)));
          end
        endcase
        cfg_we_i <= 1'b0;
      end
      idle_en = (p != 2) && (p != 5);
      for (int k = 0; k < PhaseItems; k++) random_item();
    end

    hold_sender();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d transfers: %0d updates, %0d queries, %0d clears,",
             n_items, n_update, n_query, n_clear);
    $display("%0d register writes over %0d settings, %0d results checked, %0d mismatches.",
             n_cfg, NumPhases, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("node_congestion_table_unit regression: pass");
    end else begin
      $display("node_congestion_table_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- node_congestion_table_unit.f -----
sv/nct_pkg.sv
sv/nct_div.sv
sv/node_congestion_table_unit.sv
tb/tb_node_congestion_table_unit.sv
